// File: rtl/gdw_pkg.sv
// ----------------------------------------------------------------------------
// gdw_pkg
// Shared types and codes for the gradient displacement warp unit.
// ----------------------------------------------------------------------------
`default_nettype none

package gdw_pkg;

    typedef enum logic [1:0] {
        ACT_SOURCE  = 2'd0,
        ACT_MASK    = 2'd1,
        ACT_COMPUTE = 2'd2,
        ACT_UNUSED  = 2'd3
    } action_t;

    typedef enum logic [2:0] {
        CFG_DEPTH_H  = 3'd0,
        CFG_DEPTH_V  = 3'd1,
        CFG_BITS     = 3'd2,
        CFG_UPSCALED = 3'd3,
        CFG_WIDTH    = 3'd4,
        CFG_HEIGHT   = 3'd5
    } cfg_index_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_M_ABOVE,
        ST_M_BELOW,
        ST_M_LEFT,
        ST_M_RIGHT,
        ST_M_LAST,
        ST_MUL_H,
        ST_MUL_V,
        ST_CLAMP_V,
        ST_POSITION,
        ST_LIMIT,
        ST_S_00,
        ST_S_01,
        ST_S_10,
        ST_S_11,
        ST_S_LAST,
        ST_VBLEND,
        ST_FINISH
    } state_t;

    // Width of the signed displacement and position arithmetic.
    localparam int POS_W = 26;
    localparam logic [7:0] WEIGHT_ONE = 8'd128;
    localparam logic [23:0] ROUND_HALF = 24'd64;
    localparam logic [4:0] BITS_MIN = 5'd8;
    localparam logic [4:0] BITS_MAX = 5'd16;

endpackage

`default_nettype wire

// File: rtl/gradient_displacement_warp_unit.sv
// ----------------------------------------------------------------------------
// gradient_displacement_warp_unit
// Warps a source plane along the gradient of a mask plane, bilinear blend.
// ----------------------------------------------------------------------------
// Usage: an input word is taken at a clock edge where start is high and busy
// is low. Action source or mask writes the sample into its plane at that edge
// and leaves busy low, so writes go one per cycle while no compute runs. A
// compute word at a mask coordinate inside the frame raises busy until the
// sequencer is done; the result word is shown on result_sample, out_column
// and out_row with result_valid high for a single cycle once busy falls, and a
// new word may be started in that same cycle. A compute is through before the
// next word is taken: the mask plane and the source plane each sit in one
// single-port memory, and the four mask reads, the four source reads and the
// gain, clamp and blend steps go one after another through the sequencer.
// Out-of-frame computes and the unused action are dropped; busy stays low.
// The configuration port writes a register at each edge with cfg_write high;
// the user must use it only while the unit is idle; this is not enforced.
// Reset sets the registers to defaults and the sequencer to idle; the planes
// hold nothing defined until written. The receiver cannot stall the result.
// ----------------------------------------------------------------------------
`default_nettype none

module gradient_displacement_warp_unit
    import gdw_pkg::*;
#(
    parameter int MAX_MASK_WIDTH  = 256,
    parameter int MAX_MASK_HEIGHT = 256
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [1:0]  action,
    input  wire logic [9:0]  column,
    input  wire logic [9:0]  row,
    input  wire logic [15:0] sample,
    input  wire logic        cfg_write,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [8:0]  cfg_data,
    output logic             result_valid,
    output logic [15:0]      result_sample,
    output logic [7:0]       out_column,
    output logic [7:0]       out_row
);

    localparam int SRC_COLS = 4 * MAX_MASK_WIDTH;
    localparam int SRC_ROWS = 4 * MAX_MASK_HEIGHT;
    localparam int MA_W     = $clog2(MAX_MASK_WIDTH * MAX_MASK_HEIGHT);
    localparam int SA_W     = $clog2(SRC_COLS * SRC_ROWS);
    localparam int SC_W     = $clog2(SRC_COLS);
    localparam int SR_W     = $clog2(SRC_ROWS);
    localparam int DIM_W    = $clog2(MAX_MASK_WIDTH > MAX_MASK_HEIGHT ?
                                     MAX_MASK_WIDTH + 1 : MAX_MASK_HEIGHT + 1) + 1;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic signed [7:0] depth_h_reg;
    logic signed [7:0] depth_v_reg;
    logic [4:0]        bits_reg;
    logic              upscaled_reg;
    logic [8:0]        width_reg;
    logic [8:0]        height_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            depth_h_reg  <= 8'sd3;
            depth_v_reg  <= 8'sd3;
            bits_reg     <= 5'd8;
            upscaled_reg <= 1'b0;
            width_reg    <= 9'd256;
            height_reg   <= 9'd256;
        end
        else if (cfg_write)
        begin
            case (cfg_index_t'(cfg_index))
                CFG_DEPTH_H:  depth_h_reg  <= $signed(cfg_data[7:0]);
                CFG_DEPTH_V:  depth_v_reg  <= $signed(cfg_data[7:0]);
                CFG_BITS:     bits_reg     <= cfg_data[4:0];
                CFG_UPSCALED: upscaled_reg <= cfg_data[0];
                CFG_WIDTH:    width_reg    <= cfg_data;
                CFG_HEIGHT:   height_reg   <= cfg_data;
                default:      ;
            endcase
        end
    end

    // Saturated register views.
    logic [4:0]       bits_c;
    logic [DIM_W-1:0] w_c;
    logic [DIM_W-1:0] h_c;
    logic [3:0]       gshift;
    logic signed [15:0] gain_h;
    logic signed [15:0] gain_v;

    always_comb
    begin
        if (bits_reg < BITS_MIN)
            bits_c = BITS_MIN;
        else if (bits_reg > BITS_MAX)
            bits_c = BITS_MAX;
        else
            bits_c = bits_reg;

        if (DIM_W'(width_reg) < DIM_W'(2))
            w_c = DIM_W'(2);
        else if (DIM_W'(width_reg) > DIM_W'(MAX_MASK_WIDTH))
            w_c = DIM_W'(MAX_MASK_WIDTH);
        else
            w_c = DIM_W'(width_reg);

        if (DIM_W'(height_reg) < DIM_W'(2))
            h_c = DIM_W'(2);
        else if (DIM_W'(height_reg) > DIM_W'(MAX_MASK_HEIGHT))
            h_c = DIM_W'(MAX_MASK_HEIGHT);
        else
            h_c = DIM_W'(height_reg);

        gshift = 4'(BITS_MAX - bits_c);
        gain_h = 16'(signed'(16'(depth_h_reg)) <<< gshift);
        gain_v = 16'(signed'(16'(depth_v_reg)) <<< gshift);
    end

    // ------------------------------------------------------------------
    // Sequencer and datapath registers
    // ------------------------------------------------------------------
    state_t state_reg, state_next;

    logic [9:0]  col_reg;
    logic [9:0]  row_reg;
    logic [15:0] m_up_reg, m_dn_reg, m_lf_reg;
    logic signed [16:0] dh_reg, dv_reg;
    logic signed [32:0] prod_h_reg, prod_v_reg;
    logic signed [POS_W-1:0] hd_reg, vd_reg;
    logic signed [POS_W-1:0] hpos_reg, vrow_reg;
    logic [6:0]  remh_reg, remv_reg;
    logic [SC_W-1:0] hc_reg, hn_reg;
    logic [SR_W-1:0] r0_reg;
    logic [23:0] acc_reg;
    logic [15:0] s0_reg, s1_reg;

    logic [15:0] mask_rdata;
    logic [15:0] src_rdata;

    wire logic accept = start && !busy;
    wire logic lg     = upscaled_reg;
    // Upscaled source coordinates are the mask coordinates times four.
    wire logic [1:0] lg_shift = {upscaled_reg, 1'b0};

    logic compute_ok;
    assign compute_ok = (DIM_W'(column) < w_c) && (DIM_W'(row) < h_c);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept && action_t'(action) == ACT_COMPUTE && compute_ok)
                    state_next = ST_M_ABOVE;
            end
            ST_M_ABOVE:  state_next = ST_M_BELOW;
            ST_M_BELOW:  state_next = ST_M_LEFT;
            ST_M_LEFT:   state_next = ST_M_RIGHT;
            ST_M_RIGHT:  state_next = ST_M_LAST;
            ST_M_LAST:   state_next = ST_MUL_H;
            ST_MUL_H:    state_next = ST_MUL_V;
            ST_MUL_V:    state_next = ST_CLAMP_V;
            ST_CLAMP_V:  state_next = ST_POSITION;
            ST_POSITION: state_next = ST_LIMIT;
            ST_LIMIT:    state_next = ST_S_00;
            ST_S_00:     state_next = ST_S_01;
            ST_S_01:     state_next = ST_S_10;
            ST_S_10:     state_next = ST_S_11;
            ST_S_11:     state_next = ST_S_LAST;
            ST_S_LAST:   state_next = ST_VBLEND;
            ST_VBLEND:   state_next = ST_FINISH;
            ST_FINISH:   state_next = ST_IDLE;
            default:     state_next = ST_IDLE;
        endcase
    end

    assign busy = (state_reg != ST_IDLE);

    // ------------------------------------------------------------------
    // Mask memory port
    // ------------------------------------------------------------------
    logic [DIM_W-1:0] mrow, mcol;
    logic [DIM_W-1:0] row_d, col_d;
    logic             col_edge;
    logic [MA_W-1:0]  mask_addr;
    logic             mask_we;

    assign row_d    = DIM_W'(row_reg);
    assign col_d    = DIM_W'(col_reg);
    assign col_edge = (col_reg == 10'd0) || (col_d == w_c - DIM_W'(1));

    always_comb
    begin
        mrow = row_d;
        mcol = col_d;
        case (state_reg)
            ST_IDLE:
            begin
                mrow = DIM_W'(row);
                mcol = DIM_W'(column);
            end
            ST_M_ABOVE:
                mrow = (row_reg == 10'd0) ? DIM_W'(1) : row_d - DIM_W'(1);
            ST_M_BELOW:
                mrow = (row_d == h_c - DIM_W'(1)) ? h_c - DIM_W'(2) : row_d + DIM_W'(1);
            ST_M_LEFT:
                mcol = col_edge ? col_d : col_d - DIM_W'(1);
            ST_M_RIGHT:
                mcol = col_edge ? col_d : col_d + DIM_W'(1);
            default: ;
        endcase
        mask_addr = MA_W'(mrow) * MA_W'(MAX_MASK_WIDTH) + MA_W'(mcol);
    end

    assign mask_we = accept && action_t'(action) == ACT_MASK
                     && (32'(column) < 32'(MAX_MASK_WIDTH))
                     && (32'(row) < 32'(MAX_MASK_HEIGHT));

    gdw_ram #(
        .WIDTH (16),
        .DEPTH (MAX_MASK_WIDTH * MAX_MASK_HEIGHT)
    ) u_mask_ram (
        .clk   (clk),
        .we    (mask_we),
        .addr  (mask_addr),
        .wdata (sample),
        .rdata (mask_rdata)
    );

    // ------------------------------------------------------------------
    // Source memory port
    // ------------------------------------------------------------------
    logic [SR_W-1:0] srow;
    logic [SC_W-1:0] scol;
    logic [SA_W-1:0] src_addr;
    logic            src_we;

    always_comb
    begin
        srow = r0_reg;
        scol = hc_reg;
        case (state_reg)
            ST_IDLE:
            begin
                srow = SR_W'(row);
                scol = SC_W'(column);
            end
            ST_S_01: scol = hn_reg;
            ST_S_10: srow = r0_reg + SR_W'(1);
            ST_S_11:
            begin
                srow = r0_reg + SR_W'(1);
                scol = hn_reg;
            end
            default: ;
        endcase
        src_addr = SA_W'(srow) * SA_W'(SRC_COLS) + SA_W'(scol);
    end

    assign src_we = accept && action_t'(action) == ACT_SOURCE
                    && (32'(column) < 32'(SRC_COLS))
                    && (32'(row) < 32'(SRC_ROWS));

    gdw_ram #(
        .WIDTH (16),
        .DEPTH (SRC_COLS * SRC_ROWS)
    ) u_src_ram (
        .clk   (clk),
        .we    (src_we),
        .addr  (src_addr),
        .wdata (sample),
        .rdata (src_rdata)
    );

    // ------------------------------------------------------------------
    // Arithmetic
    // ------------------------------------------------------------------
    logic signed [POS_W-1:0] y_p, x_p, h_p, w_p;
    logic signed [POS_W-1:0] v_lo, v_hi, hsh, vsh;
    logic signed [POS_W-1:0] xmax, nmax, hclamp, hnext;
    logic [7:0]  wt_h, wt_v;
    logic [23:0] blend;
    logic [16:0] peak;

    always_comb
    begin
        y_p   = POS_W'(row_reg);
        x_p   = POS_W'(col_reg);
        h_p   = POS_W'(h_c);
        w_p   = POS_W'(w_c);
        v_lo  = -(y_p <<< 7);
        v_hi  = ((h_p - y_p) <<< 7) - POS_W'(129);
        hsh   = lg ? (hd_reg >>> 5) : (hd_reg >>> 7);
        vsh   = lg ? (vd_reg >>> 5) : (vd_reg >>> 7);
        xmax  = (w_p - POS_W'(1)) <<< lg_shift;
        nmax  = (w_p <<< lg_shift) - POS_W'(1);
        if (hpos_reg < 0)
            hclamp = '0;
        else if (hpos_reg > xmax)
            hclamp = xmax;
        else
            hclamp = hpos_reg;
        hnext = (hclamp + POS_W'(1) > nmax) ? nmax : hclamp + POS_W'(1);
        wt_h  = WEIGHT_ONE - 8'(remh_reg);
        wt_v  = WEIGHT_ONE - 8'(remv_reg);
        blend = acc_reg + 24'(s1_reg) * 24'(remv_reg) + ROUND_HALF;
        peak  = (17'd1 << bits_c) - 17'd1;
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                col_reg <= column;
                row_reg <= row;
            end
            ST_M_BELOW: m_up_reg <= mask_rdata;
            ST_M_LEFT:  m_dn_reg <= mask_rdata;
            ST_M_RIGHT: m_lf_reg <= mask_rdata;
            ST_M_LAST:
            begin
                dv_reg <= $signed({1'b0, m_up_reg}) - $signed({1'b0, m_dn_reg});
                dh_reg <= col_edge ? 17'sd0
                          : $signed({1'b0, m_lf_reg}) - $signed({1'b0, mask_rdata});
            end
            ST_MUL_H: prod_h_reg <= 33'(dh_reg) * 33'(gain_h);
            ST_MUL_V: prod_v_reg <= 33'(dv_reg) * 33'(gain_v);
            ST_CLAMP_V:
            begin
                hd_reg <= POS_W'(prod_h_reg >>> 9);
                if (POS_W'(prod_v_reg >>> 9) < v_lo)
                    vd_reg <= v_lo;
                else if (POS_W'(prod_v_reg >>> 9) > v_hi)
                    vd_reg <= v_hi;
                else
                    vd_reg <= POS_W'(prod_v_reg >>> 9);
            end
            ST_POSITION:
            begin
                hpos_reg <= hsh + (x_p <<< lg_shift);
                vrow_reg <= vsh + (y_p <<< lg_shift);
                remh_reg <= lg ? {hd_reg[4:0], 2'b00} : hd_reg[6:0];
                remv_reg <= lg ? {vd_reg[4:0], 2'b00} : vd_reg[6:0];
            end
            ST_LIMIT:
            begin
                // Fraction is dropped unless the point lies strictly inside.
                if (!(hpos_reg >= 0 && hpos_reg < xmax))
                    remh_reg <= '0;
                hc_reg <= SC_W'(hclamp);
                hn_reg <= SC_W'(hnext);
                r0_reg <= SR_W'(vrow_reg);
            end
            ST_S_01: acc_reg <= 24'(src_rdata) * 24'(wt_h);
            ST_S_10:
                s0_reg <= 16'((acc_reg + 24'(src_rdata) * 24'(remh_reg) + ROUND_HALF) >> 7);
            ST_S_11: acc_reg <= 24'(src_rdata) * 24'(wt_h);
            ST_S_LAST:
                s1_reg <= 16'((acc_reg + 24'(src_rdata) * 24'(remh_reg) + ROUND_HALF) >> 7);
            ST_VBLEND: acc_reg <= 24'(s0_reg) * 24'(wt_v);
            ST_FINISH:
            begin
                result_sample <= (17'(blend >> 7) > peak) ? peak[15:0] : 16'(blend >> 7);
                out_column    <= col_reg[7:0];
                out_row       <= row_reg[7:0];
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            result_valid <= 1'b0;
        else
            result_valid <= (state_reg == ST_FINISH);
    end

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_valid_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |=> !result_valid)
        else $error("result word held for more than one cycle");

    a_valid_idle: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> !busy)
        else $error("result word shown while the sequencer is still running");

    a_compute_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && action_t'(action) == ACT_COMPUTE && compute_ok) |=> busy)
        else $error("accepted compute word did not start the sequencer");

    a_no_write_busy: assert property (@(posedge clk) disable iff (!rst_n)
        busy |-> !mask_we && !src_we)
        else $error("plane write while the sequencer owns the memories");

endmodule

`default_nettype wire

// File: rtl/gdw_ram.sv
// ----------------------------------------------------------------------------
// gdw_ram
// Generic single-port synchronous RAM with a registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module gdw_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] addr,
    input  wire logic [WIDTH-1:0]         wdata,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

`default_nettype wire

// File: sim/gradient_displacement_warp_unit_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// gradient_displacement_warp_unit_tb
// Self-checking bench: loads mask and source planes, issues computes under a
// series of register settings and compares every result word with a
// behavioral warp predictor kept alongside the unit.
// ----------------------------------------------------------------------------
module gradient_displacement_warp_unit_tb;
    import gdw_pkg::*;

    typedef enum logic [1:0] {K_WORD, K_CFG, K_DRAIN} item_kind_t;

    typedef struct {
        item_kind_t kind;
        action_t    act;
        logic [9:0] col;
        logic [9:0] row;
        logic [15:0] smp;
        cfg_index_t idx;
        logic [8:0] data;
    } item_t;

    typedef struct {
        logic [15:0] smp;
        logic [7:0]  col;
        logic [7:0]  row;
    } warp_out_t;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic [1:0]  action;
    logic [9:0]  column;
    logic [9:0]  row;
    logic [15:0] sample;
    logic        cfg_write;
    logic [2:0]  cfg_index;
    logic [8:0]  cfg_data;
    logic        result_valid;
    logic [15:0] result_sample;
    logic [7:0]  out_column;
    logic [7:0]  out_row;

    gradient_displacement_warp_unit u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .action       (action),
        .column       (column),
        .row          (row),
        .sample       (sample),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .result_valid (result_valid),
        .result_sample(result_sample),
        .out_column   (out_column),
        .out_row      (out_row)
    );

    item_t       pending_words[$];
    warp_out_t   expected_warps[$];
    logic [15:0] source_plane[int];
    logic [15:0] mask_plane[int];

    // Shadow registers, raw as written.
    logic [7:0]  depth_h_reg;
    logic [7:0]  depth_v_reg;
    logic [4:0]  bits_reg;
    logic        upscaled_reg;
    logic [8:0]  width_reg;
    logic [8:0]  height_reg;

    logic        holding;
    int          gap_left;
    int          burst_left;
    int          quiet_cycles;
    int          errors;

    initial clk = 1'b0;
    always #6 clk = ~clk;

    function automatic longint read_mask(longint r, longint c);
        int key;
        key = int'(r * 256 + c);
        return mask_plane.exists(key) ? longint'(mask_plane[key]) : 0;
    endfunction

    function automatic longint read_source(longint r, longint c);
        int key;
        key = int'(r * 1024 + c);
        return source_plane.exists(key) ? longint'(source_plane[key]) : 0;
    endfunction

    function automatic logic [15:0] warp_sample(longint x, longint y);
        longint bits, w, h, lg, scale, above, below, dv, dh, gain, hd, vd;
        longint remh, remv, xmax, hn, r0, s0, s1, s, peak;
        bits = bits_reg < 8 ? 8 : (bits_reg > 16 ? 16 : bits_reg);
        w = width_reg < 2 ? 2 : (width_reg > 256 ? 256 : width_reg);
        h = height_reg < 2 ? 2 : (height_reg > 256 ? 256 : height_reg);
        lg = upscaled_reg ? 2 : 0;
        scale = 1 << lg;
        above = (y == 0) ? 1 : y - 1;
        below = (y == h - 1) ? h - 2 : y + 1;
        dv = read_mask(above, x) - read_mask(below, x);
        dh = 0;
        if (x > 0 && x < w - 1)
            dh = read_mask(y, x - 1) - read_mask(y, x + 1);
        gain = longint'(1) << (16 - bits);
        hd = (dh * 128 * (longint'($signed(depth_h_reg)) * gain)) >>> 16;
        vd = (dv * 128 * (longint'($signed(depth_v_reg)) * gain)) >>> 16;
        if (vd < -y * 128)
            vd = -y * 128;
        if (vd > (h - y) * 128 - 129)
            vd = (h - y) * 128 - 129;
        remh = (hd << lg) & 127;
        remv = (vd << lg) & 127;
        hd = (hd >>> (7 - lg)) + x * scale;
        vd = vd >>> (7 - lg);
        xmax = (w - 1) * scale;
        // The fraction only counts while the column is strictly inside the frame.
        if (!(hd >= 0 && hd < xmax))
            remh = 0;
        hd = hd < 0 ? 0 : (hd > xmax ? xmax : hd);
        hn = hd + 1 > w * scale - 1 ? w * scale - 1 : hd + 1;
        r0 = y * scale + vd;
        s0 = read_source(r0, hd) * (128 - remh) + read_source(r0, hn) * remh;
        s1 = read_source(r0 + 1, hd) * (128 - remh) + read_source(r0 + 1, hn) * remh;
        s0 = (s0 + 64) >> 7;
        s1 = (s1 + 64) >> 7;
        s = (s0 * (128 - remv) + s1 * remv + 64) >> 7;
        peak = (longint'(1) << bits) - 1;
        if (s > peak)
            s = peak;
        return s[15:0];
    endfunction

    task automatic apply_word(item_t it);
        longint w, h;
        warp_out_t e;
        w = width_reg < 2 ? 2 : (width_reg > 256 ? 256 : width_reg);
        h = height_reg < 2 ? 2 : (height_reg > 256 ? 256 : height_reg);
        case (it.act)
            ACT_SOURCE: source_plane[int'(it.row) * 1024 + int'(it.col)] = it.smp;
            ACT_MASK:
                if (it.col < 256 && it.row < 256)
                    mask_plane[int'(it.row) * 256 + int'(it.col)] = it.smp;
            ACT_COMPUTE:
                if (it.col < w && it.row < h)
                begin
                    e.smp = warp_sample(it.col, it.row);
                    e.col = it.col[7:0];
                    e.row = it.row[7:0];
                    expected_warps.push_back(e);
                end
            default: ;
        endcase
    endtask

    function automatic item_t make_word(action_t a, int c, int r, int s);
        item_t it;
        it.kind = K_WORD;
        it.act = a;
        it.col = c[9:0];
        it.row = r[9:0];
        it.smp = s[15:0];
        it.idx = CFG_DEPTH_H;
        it.data = '0;
        return it;
    endfunction

    task automatic push_cfg(cfg_index_t idx, int value);
        item_t it;
        it = make_word(ACT_UNUSED, 0, 0, 0);
        it.kind = K_CFG;
        it.idx = idx;
        it.data = value[8:0];
        pending_words.push_back(it);
    endtask

    task automatic push_drain();
        item_t it;
        it = make_word(ACT_UNUSED, 0, 0, 0);
        it.kind = K_DRAIN;
        pending_words.push_back(it);
    endtask

    // Sets every register and loads both planes over the whole frame, so that
    // no compute ever reads an entry that was never written.
    task automatic load_phase(int dh, int dv, int bits, int up, int wraw, int hraw);
        int w, h, scale, amp;
        w = wraw < 2 ? 2 : (wraw > 256 ? 256 : wraw);
        h = hraw < 2 ? 2 : (hraw > 256 ? 256 : hraw);
        scale = up ? 4 : 1;
        case ($urandom_range(0, 2))
            0: amp = 65535;
            1: amp = 255;
            default: amp = 15;
        endcase
        push_drain();
        push_cfg(CFG_DEPTH_H, dh);
        push_cfg(CFG_DEPTH_V, dv);
        push_cfg(CFG_BITS, bits);
        push_cfg(CFG_UPSCALED, up);
        push_cfg(CFG_WIDTH, wraw);
        push_cfg(CFG_HEIGHT, hraw);
        for (int r = 0; r < h; r++)
            for (int c = 0; c < w; c++)
                pending_words.push_back(make_word(ACT_MASK, c, r, $urandom_range(0, amp)));
        for (int r = 0; r < h * scale; r++)
            for (int c = 0; c < w * scale; c++)
                pending_words.push_back(make_word(ACT_SOURCE, c, r, $urandom()));
    endtask

    // Large frames: only the patch from column c_lo and row r_lo to the far
    // corner is loaded. The mask there is flat, so the displacement is zero and
    // every read stays inside the patch. Computes land in the patch or anywhere
    // past the saturated frame, where they must be dropped.
    task automatic patch_phase(int dh, int dv, int bits, int up, int wraw, int hraw,
                               int c_lo, int r_lo, int count);
        int w, h, scale, level;
        w = wraw < 2 ? 2 : (wraw > 256 ? 256 : wraw);
        h = hraw < 2 ? 2 : (hraw > 256 ? 256 : hraw);
        scale = up ? 4 : 1;
        level = $urandom_range(0, 65535);
        push_drain();
        push_cfg(CFG_DEPTH_H, dh);
        push_cfg(CFG_DEPTH_V, dv);
        push_cfg(CFG_BITS, bits);
        push_cfg(CFG_UPSCALED, up);
        push_cfg(CFG_WIDTH, wraw);
        push_cfg(CFG_HEIGHT, hraw);
        for (int r = (r_lo > 0 ? r_lo - 1 : 0); r < h; r++)
            for (int c = (c_lo > 0 ? c_lo - 1 : 0); c < w; c++)
                pending_words.push_back(make_word(ACT_MASK, c, r, level));
        for (int r = (r_lo > 0 ? r_lo * scale - 1 : 0); r < h * scale; r++)
            for (int c = c_lo * scale; c < w * scale; c++)
                pending_words.push_back(make_word(ACT_SOURCE, c, r, $urandom()));
        for (int n = 0; n < count; n++)
        begin
            case ($urandom_range(0, 5))
                0: pending_words.push_back(make_word(ACT_COMPUTE, $urandom_range(w, 1023),
                       $urandom_range(r_lo, 1023), 0));
                1: pending_words.push_back(make_word(ACT_COMPUTE, $urandom_range(c_lo, w - 1),
                       $urandom_range(h, 1023), 0));
                default: pending_words.push_back(make_word(ACT_COMPUTE,
                       $urandom_range(c_lo, w - 1), $urandom_range(r_lo, h - 1), 0));
            endcase
        end
    endtask

    task automatic random_traffic(int wraw, int hraw, int up, int count);
        int w, h, scale, pick;
        w = wraw < 2 ? 2 : (wraw > 256 ? 256 : wraw);
        h = hraw < 2 ? 2 : (hraw > 256 ? 256 : hraw);
        scale = up ? 4 : 1;
        for (int n = 0; n < count; n++)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 65)
                pending_words.push_back(make_word(ACT_COMPUTE, $urandom_range(0, w - 1),
                    $urandom_range(0, h - 1), $urandom()));
            else if (pick < 73)
                pending_words.push_back(make_word(ACT_COMPUTE, $urandom_range(0, 1023),
                    $urandom_range(0, 1023), $urandom()));
            else if (pick < 83)
                pending_words.push_back(make_word(ACT_SOURCE, $urandom_range(0, w * scale - 1),
                    $urandom_range(0, h * scale - 1), $urandom()));
            else if (pick < 90)
                pending_words.push_back(make_word(ACT_MASK, $urandom_range(0, w - 1),
                    $urandom_range(0, h - 1), $urandom()));
            else if (pick < 95)
                pending_words.push_back(make_word(ACT_MASK, $urandom_range(256, 1023),
                    $urandom_range(0, 1023), $urandom()));
            else
                pending_words.push_back(make_word(ACT_UNUSED, $urandom_range(0, 1023),
                    $urandom_range(0, 1023), $urandom()));
            if (n == count / 2)
                push_drain();
        end
    endtask

    // Driver: words change on the falling edge.
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            cfg_write <= 1'b0;
            if (!holding)
            begin
                if (pending_words.size() == 0)
                    start <= 1'b0;
                else if (pending_words[0].kind == K_CFG)
                begin
                    start <= 1'b0;
                    cfg_write <= 1'b1;
                    cfg_index <= pending_words[0].idx;
                    cfg_data <= pending_words[0].data;
                    case (pending_words[0].idx)
                        CFG_DEPTH_H:  depth_h_reg <= pending_words[0].data[7:0];
                        CFG_DEPTH_V:  depth_v_reg <= pending_words[0].data[7:0];
                        CFG_BITS:     bits_reg <= pending_words[0].data[4:0];
                        CFG_UPSCALED: upscaled_reg <= pending_words[0].data[0];
                        CFG_WIDTH:    width_reg <= pending_words[0].data;
                        default:      height_reg <= pending_words[0].data;
                    endcase
                    void'(pending_words.pop_front());
                end
                else if (pending_words[0].kind == K_DRAIN)
                begin
                    start <= 1'b0;
                    if (expected_warps.size() == 0 && quiet_cycles >= 24)
                        void'(pending_words.pop_front());
                end
                else if (gap_left > 0)
                begin
                    start <= 1'b0;
                    gap_left <= gap_left - 1;
                end
                else
                begin
                    start <= 1'b1;
                    action <= pending_words[0].act;
                    column <= pending_words[0].col;
                    row <= pending_words[0].row;
                    sample <= pending_words[0].smp;
                    holding <= 1'b1;
                    if (burst_left == 0)
                    begin
                        burst_left <= $urandom_range(1, 40);
                        gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 9);
                    end
                    else
                        burst_left <= burst_left - 1;
                end
            end
        end
    end

    // Monitor: acceptance and results are sampled on the rising edge.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (start && !busy && holding)
            begin
                apply_word(pending_words[0]);
                void'(pending_words.pop_front());
                holding <= 1'b0;
            end
            if (result_valid)
            begin
                if (expected_warps.size() == 0)
                begin
                    $display("%0t: unexpected word sample=%0d col=%0d row=%0d", $realtime,
                        result_sample, out_column, out_row);
                    errors++;
                end
                else
                begin
                    warp_out_t e;
                    e = expected_warps.pop_front();
                    if (result_sample !== e.smp)
                    begin
                        $display("%0t: result_sample expected %0d actual %0d", $realtime,
                            e.smp, result_sample);
                        errors++;
                    end
                    if (out_column !== e.col)
                    begin
                        $display("%0t: out_column expected %0d actual %0d", $realtime,
                            e.col, out_column);
                        errors++;
                    end
                    if (out_row !== e.row)
                    begin
                        $display("%0t: out_row expected %0d actual %0d", $realtime,
                            e.row, out_row);
                        errors++;
                    end
                end
            end
            if ((start && !busy) || result_valid || busy)
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial
    begin
        int dh, dv, w, h, up;
        rst_n = 1'b0;
        start = 1'b0;
        action = ACT_SOURCE;
        column = '0;
        row = '0;
        sample = '0;
        cfg_write = 1'b0;
        cfg_index = CFG_DEPTH_H;
        cfg_data = '0;
        depth_h_reg = 8'd3;
        depth_v_reg = 8'd3;
        bits_reg = 5'd8;
        upscaled_reg = 1'b0;
        width_reg = 9'd256;
        height_reg = 9'd256;
        holding = 1'b0;
        gap_left = 0;
        burst_left = 0;
        quiet_cycles = 0;
        errors = 0;

        // Directed part: every coordinate of a tiny frame, so corners and edges
        // all come up, plus dropped unused, compute and mask words.
        load_phase(3, 3, 8, 0, 4, 3);
        for (int r = 0; r < 3; r++)
            for (int c = 0; c < 4; c++)
                pending_words.push_back(make_word(ACT_COMPUTE, c, r, 16'hFFFF));
        pending_words.push_back(make_word(ACT_UNUSED, 1023, 1023, 16'hFFFF));
        pending_words.push_back(make_word(ACT_COMPUTE, 4, 0, 0));
        pending_words.push_back(make_word(ACT_COMPUTE, 0, 3, 0));
        pending_words.push_back(make_word(ACT_COMPUTE, 1023, 1023, 0));
        pending_words.push_back(make_word(ACT_MASK, 1023, 1023, 16'hFFFF));
        pending_words.push_back(make_word(ACT_MASK, 1, 1, 16'hFFFF));
        pending_words.push_back(make_word(ACT_COMPUTE, 2, 1, 0));
        pending_words.push_back(make_word(ACT_COMPUTE, 1, 0, 0));

        // Register extremes, including values that saturate.
        load_phase(127, -128, 16, 0, 8, 8);
        random_traffic(8, 8, 0, 80);
        load_phase(-128, 127, 8, 1, 3, 2);
        random_traffic(3, 2, 1, 70);
        load_phase(0, 0, 12, 0, 5, 5);
        random_traffic(5, 5, 0, 40);
        load_phase(255, 1, 0, 1, 1, 0);
        random_traffic(1, 0, 1, 60);
        patch_phase(-1, 127, 31, 0, 300, 2, 250, 0, 40);
        patch_phase(64, -64, 10, 1, 511, 2, 253, 0, 30);
        patch_phase(-77, 90, 9, 1, 2, 400, 0, 252, 40);

        for (int p = 0; p < 2; p++)
        begin
            dh = $urandom_range(0, 511);
            dv = $urandom_range(0, 511);
            up = $urandom_range(0, 1);
            w = up ? $urandom_range(2, 3) : $urandom_range(2, 8);
            h = up ? $urandom_range(2, 3) : $urandom_range(2, 8);
            load_phase(dh, dv, $urandom_range(0, 31), up, w, h);
            random_traffic(w, h, up, 50);
        end

        #144;
        rst_n = 1'b1;

        wait (pending_words.size() == 0);
        while (expected_warps.size() != 0)
            @(posedge clk);
        repeat (30) @(posedge clk);
        if (errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    initial
    begin
        #10ms;
        $display("*** FAILED ***");
        $finish;
    end

endmodule

// File: filelist.f
rtl/gdw_pkg.sv
rtl/gdw_ram.sv
rtl/gradient_displacement_warp_unit.sv
sim/gradient_displacement_warp_unit_tb.sv
